/* src/tpla_pkg.sv */
// Shared types and constants for the texture pool allocator.
`timescale 1ns / 1ps
`default_nettype none
package tpla_pkg;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned SLOT_W      = $clog2(SLOTS);
  localparam int unsigned FREE_W      = $clog2(SLOTS + 1);
  localparam int unsigned MAX_DIM     = 4096;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned BYTES_W     = 28;
  localparam int unsigned POOL_W      = 32;

  localparam logic [2:0] FMT_RGBA = 3'd4;
  localparam logic       ACT_RELEASE = 1'b1;

  localparam logic [2:0] OC_NEW      = 3'd0;
  localparam logic [2:0] OC_REUSED   = 3'd1;
  localparam logic [2:0] OC_RELEASED = 3'd2;
  localparam logic [2:0] OC_EVICTED  = 3'd3;
  localparam logic [2:0] OC_FULL     = 3'd4;
  localparam logic [2:0] OC_NOT_USED = 3'd5;

  localparam logic [POOL_W-1:0] BUDGET_RST = 32'd67108864;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_USED  = 2'd1,
    ST_FREE  = 2'd2
  } slot_st_t;

  typedef enum logic [2:0] {
    TBL_NONE    = 3'd0,
    TBL_FILL    = 3'd1,
    TBL_REUSE   = 3'd2,
    TBL_EVICT   = 3'd3,
    TBL_RELEASE = 3'd4
  } tbl_op_t;

  typedef struct packed {
    logic             action;
    logic [DIM_W-1:0] req_width;
    logic [DIM_W-1:0] req_height;
    logic [2:0]       req_format;
    logic             req_channel_type;
    logic [3:0]       slot_id;
  } req_t;

  typedef struct packed {
    logic [3:0]        result_slot;
    logic [2:0]        outcome;
    logic [POOL_W-1:0] pool_total;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [2:0]       format;
    logic             chan;
  } desc_t;

  typedef struct packed {
    slot_st_t           status;
    desc_t              desc;
    logic [BYTES_W-1:0] bytes;
    logic [SLOT_W-1:0]  rank;
  } slot_ent_t;

  typedef struct packed {
    tbl_op_t            op;
    logic [SLOT_W-1:0]  idx;
    logic [SLOT_W-1:0]  ref_rank;
    logic [SLOT_W-1:0]  new_rank;
    desc_t              desc;
    logic [BYTES_W-1:0] bytes;
  } tbl_cmd_t;

endpackage
`default_nettype wire

/* src/tpla_slot_table.sv */
// Slot table: status, descriptor, size and recency rank of every slot.
`timescale 1ns / 1ps
`default_nettype none
module tpla_slot_table
  import tpla_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [SLOT_W-1:0] scan_idx_i,
  input  wire tbl_cmd_t          cmd_i,
  output slot_ent_t              scan_ent_o
);

  slot_st_t           status_r [SLOTS];
  slot_st_t           status_nxt [SLOTS];
  logic [SLOT_W-1:0]  rank_r [SLOTS];
  logic [SLOT_W-1:0]  rank_nxt [SLOTS];
  desc_t              desc_r [SLOTS];
  logic [BYTES_W-1:0] bytes_r [SLOTS];

  assign scan_ent_o.status = status_r[scan_idx_i];
  assign scan_ent_o.desc   = desc_r[scan_idx_i];
  assign scan_ent_o.bytes  = bytes_r[scan_idx_i];
  assign scan_ent_o.rank   = rank_r[scan_idx_i];

  always_comb begin
    for (int t = 0; t < SLOTS; t++) begin
      status_nxt[t] = status_r[t];
      rank_nxt[t]   = rank_r[t];
      // close the gap left by a slot leaving the free order
      if (((cmd_i.op == TBL_REUSE) || (cmd_i.op == TBL_EVICT)) &&
          (SLOT_W'(t) != cmd_i.idx) && (status_r[t] == ST_FREE) &&
          (rank_r[t] > cmd_i.ref_rank)) begin
        rank_nxt[t] = rank_r[t] - 1'b1;
      end
      if (SLOT_W'(t) == cmd_i.idx) begin
        case (cmd_i.op)
          TBL_FILL, TBL_REUSE: begin
            status_nxt[t] = ST_USED;
            rank_nxt[t]   = '0;
          end
          TBL_EVICT: begin
            status_nxt[t] = ST_EMPTY;
            rank_nxt[t]   = '0;
          end
          TBL_RELEASE: begin
            status_nxt[t] = ST_FREE;
            rank_nxt[t]   = cmd_i.new_rank;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < SLOTS; t++) begin
        status_r[t] <= ST_EMPTY;
        rank_r[t]   <= '0;
      end
    end else begin
      for (int t = 0; t < SLOTS; t++) begin
        status_r[t] <= status_nxt[t];
        rank_r[t]   <= rank_nxt[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.op == TBL_FILL) begin
      desc_r[cmd_i.idx]  <= cmd_i.desc;
      bytes_r[cmd_i.idx] <= cmd_i.bytes;
    end
  end

endmodule
`default_nettype wire

/* src/tpla_seq.sv */
// Request sequencer: slot scan, grant, release and budget eviction.
`timescale 1ns / 1ps
`default_nettype none
module tpla_seq
  import tpla_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid_i,
  input  wire req_t              in_data_i,
  output logic                   in_stall_o,
  input  wire logic [POOL_W-1:0] budget_i,
  input  wire logic              can_emit_i,
  output logic                   emit_o,
  output res_t                   res_o,
  output logic [SLOT_W-1:0]      scan_idx_o,
  input  wire slot_ent_t         scan_ent_i,
  output tbl_cmd_t               cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_ALLOC  = 7'b0000100,
    S_FILL   = 7'b0001000,
    S_REL    = 7'b0010000,
    S_TSCAN  = 7'b0100000,
    S_TEVICT = 7'b1000000
  } state_t;

  localparam logic [CNT_W-1:0]  MAX_RES_C = CNT_W'(MAX_RESULTS);
  localparam logic [DIM_W-1:0]  DIM_MAX_C = DIM_W'(MAX_DIM);
  localparam logic [SLOT_W-1:0] LAST_IDX  = SLOT_W'(SLOTS - 1);

  state_t                state_r, state_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  req_t                  req_r, req_nxt;
  logic                  match_found_r, match_found_nxt;
  logic [SLOT_W-1:0]     match_idx_r, match_idx_nxt;
  logic [SLOT_W-1:0]     match_rank_r, match_rank_nxt;
  logic                  empty_found_r, empty_found_nxt;
  logic [SLOT_W-1:0]     empty_idx_r, empty_idx_nxt;
  logic                  victim_found_r, victim_found_nxt;
  logic [SLOT_W-1:0]     victim_idx_r, victim_idx_nxt;
  logic [BYTES_W-1:0]    victim_bytes_r, victim_bytes_nxt;
  logic [2*DIM_W-1:0]    prod_r, prod_nxt;
  logic [POOL_W-1:0]     pool_r, pool_nxt;
  logic [FREE_W-1:0]     free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;

  logic [BYTES_W-1:0]    req_bytes;
  logic [POOL_W:0]       pool_sum;
  logic [POOL_W-1:0]     pool_add;
  logic [POOL_W-1:0]     pool_sub;
  desc_t                 req_desc;
  logic                  ent_match;

  function automatic logic more_f(logic [CNT_W-1:0] n, logic [POOL_W-1:0] p,
                                  logic [POOL_W-1:0] b, logic [FREE_W-1:0] f);
    return (n < MAX_RES_C) && (p > b) && (f != '0);
  endfunction

  // Scale the stored width times height by channel count and channel bytes.
  always_comb begin
    req_bytes = BYTES_W'(prod_r);
    if (req_r.req_format == FMT_RGBA) req_bytes = req_bytes << 2;
    if (req_r.req_channel_type)       req_bytes = req_bytes << 1;
  end

  assign pool_sum = {1'b0, pool_r} + {{(POOL_W + 1 - BYTES_W){1'b0}}, req_bytes};
  assign pool_add = pool_sum[POOL_W] ? {POOL_W{1'b1}} : pool_sum[POOL_W-1:0];
  assign pool_sub = (pool_r >= POOL_W'(victim_bytes_r)) ?
                    pool_r - POOL_W'(victim_bytes_r) : '0;

  assign req_desc.width  = req_r.req_width;
  assign req_desc.height = req_r.req_height;
  assign req_desc.format = req_r.req_format;
  assign req_desc.chan   = req_r.req_channel_type;
  assign ent_match       = (scan_ent_i.status == ST_FREE) && (scan_ent_i.desc == req_desc);

  assign in_stall_o = (state_r != S_IDLE);
  assign scan_idx_o = (state_r == S_REL) ? req_r.slot_id : idx_r;

  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    req_nxt          = req_r;
    match_found_nxt  = match_found_r;
    match_idx_nxt    = match_idx_r;
    match_rank_nxt   = match_rank_r;
    empty_found_nxt  = empty_found_r;
    empty_idx_nxt    = empty_idx_r;
    victim_found_nxt = victim_found_r;
    victim_idx_nxt   = victim_idx_r;
    victim_bytes_nxt = victim_bytes_r;
    prod_nxt         = prod_r;
    pool_nxt         = pool_r;
    free_cnt_nxt     = free_cnt_r;
    n_nxt            = n_r;
    emit_o           = 1'b0;
    res_o            = '0;
    cmd_o.op         = TBL_NONE;
    cmd_o.idx        = victim_idx_r;
    cmd_o.ref_rank   = '0;
    cmd_o.new_rank   = free_cnt_r[SLOT_W-1:0];
    cmd_o.desc       = req_desc;
    cmd_o.bytes      = req_bytes;

    case (state_r)
      S_IDLE: begin
        if (in_valid_i) begin
          req_nxt = in_data_i;
          if (in_data_i.req_width > DIM_MAX_C)  req_nxt.req_width  = DIM_MAX_C;
          if (in_data_i.req_height > DIM_MAX_C) req_nxt.req_height = DIM_MAX_C;
          idx_nxt          = '0;
          n_nxt            = '0;
          match_found_nxt  = 1'b0;
          empty_found_nxt  = 1'b0;
          victim_found_nxt = 1'b0;
          state_nxt        = (in_data_i.action == ACT_RELEASE) ? S_REL : S_SCAN;
        end
      end

      S_SCAN: begin
        prod_nxt = req_r.req_width * req_r.req_height;
        if (ent_match && !match_found_r) begin
          match_found_nxt = 1'b1;
          match_idx_nxt   = idx_r;
          match_rank_nxt  = scan_ent_i.rank;
        end
        if ((scan_ent_i.status == ST_EMPTY) && !empty_found_r) begin
          empty_found_nxt = 1'b1;
          empty_idx_nxt   = idx_r;
        end
        if ((scan_ent_i.status == ST_FREE) && (scan_ent_i.rank == '0)) begin
          victim_found_nxt = 1'b1;
          victim_idx_nxt   = idx_r;
          victim_bytes_nxt = scan_ent_i.bytes;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) state_nxt = S_ALLOC;
      end

      S_ALLOC: begin
        if (can_emit_i) begin
          emit_o = 1'b1;
          n_nxt  = CNT_W'(1);
          if (match_found_r) begin
            cmd_o.op          = TBL_REUSE;
            cmd_o.idx         = match_idx_r;
            cmd_o.ref_rank    = match_rank_r;
            free_cnt_nxt      = free_cnt_r - 1'b1;
            res_o.result_slot = match_idx_r;
            res_o.outcome     = OC_REUSED;
          end else if (empty_found_r) begin
            cmd_o.op          = TBL_FILL;
            cmd_o.idx         = empty_idx_r;
            pool_nxt          = pool_add;
            res_o.result_slot = empty_idx_r;
            res_o.outcome     = OC_NEW;
          end else if (victim_found_r) begin
            // evict the oldest free slot, then grant it in the next step
            cmd_o.op          = TBL_EVICT;
            free_cnt_nxt      = free_cnt_r - 1'b1;
            pool_nxt          = pool_sub;
            res_o.result_slot = victim_idx_r;
            res_o.outcome     = OC_EVICTED;
          end else begin
            res_o.outcome     = OC_FULL;
          end
          res_o.pool_total = pool_nxt;
          if (!match_found_r && !empty_found_r && victim_found_r) begin
            res_o.last = 1'b0;
            state_nxt  = S_FILL;
          end else if (!match_found_r && !empty_found_r) begin
            res_o.last = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            res_o.last       = !more_f(n_nxt, pool_nxt, budget_i, free_cnt_nxt);
            state_nxt        = res_o.last ? S_IDLE : S_TSCAN;
            idx_nxt          = '0;
            victim_found_nxt = 1'b0;
          end
        end
      end

      S_FILL: begin
        if (can_emit_i) begin
          cmd_o.op          = TBL_FILL;
          pool_nxt          = pool_add;
          n_nxt             = n_r + 1'b1;
          emit_o            = 1'b1;
          res_o.result_slot = victim_idx_r;
          res_o.outcome     = OC_NEW;
          res_o.pool_total  = pool_nxt;
          res_o.last        = !more_f(n_nxt, pool_nxt, budget_i, free_cnt_r);
          state_nxt         = res_o.last ? S_IDLE : S_TSCAN;
          idx_nxt           = '0;
          victim_found_nxt  = 1'b0;
        end
      end

      S_REL: begin
        if (can_emit_i) begin
          emit_o            = 1'b1;
          n_nxt             = CNT_W'(1);
          res_o.result_slot = req_r.slot_id;
          res_o.pool_total  = pool_r;
          if (scan_ent_i.status != ST_USED) begin
            res_o.outcome = OC_NOT_USED;
            res_o.last    = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd_o.op         = TBL_RELEASE;
            cmd_o.idx        = req_r.slot_id;
            free_cnt_nxt     = free_cnt_r + 1'b1;
            res_o.outcome    = OC_RELEASED;
            res_o.last       = !more_f(n_nxt, pool_r, budget_i, free_cnt_nxt);
            state_nxt        = res_o.last ? S_IDLE : S_TSCAN;
            idx_nxt          = '0;
            victim_found_nxt = 1'b0;
          end
        end
      end

      S_TSCAN: begin
        if ((scan_ent_i.status == ST_FREE) && (scan_ent_i.rank == '0)) begin
          victim_found_nxt = 1'b1;
          victim_idx_nxt   = idx_r;
          victim_bytes_nxt = scan_ent_i.bytes;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) state_nxt = S_TEVICT;
      end

      S_TEVICT: begin
        if (can_emit_i) begin
          cmd_o.op          = TBL_EVICT;
          free_cnt_nxt      = free_cnt_r - 1'b1;
          pool_nxt          = pool_sub;
          n_nxt             = n_r + 1'b1;
          emit_o            = 1'b1;
          res_o.result_slot = victim_idx_r;
          res_o.outcome     = OC_EVICTED;
          res_o.pool_total  = pool_nxt;
          res_o.last        = !more_f(n_nxt, pool_nxt, budget_i, free_cnt_nxt);
          state_nxt         = res_o.last ? S_IDLE : S_TSCAN;
          idx_nxt           = '0;
          victim_found_nxt  = 1'b0;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      pool_r         <= '0;
      free_cnt_r     <= '0;
      n_r            <= '0;
      match_found_r  <= 1'b0;
      empty_found_r  <= 1'b0;
      victim_found_r <= 1'b0;
      idx_r          <= '0;
    end else begin
      state_r        <= state_nxt;
      pool_r         <= pool_nxt;
      free_cnt_r     <= free_cnt_nxt;
      n_r            <= n_nxt;
      match_found_r  <= match_found_nxt;
      empty_found_r  <= empty_found_nxt;
      victim_found_r <= victim_found_nxt;
      idx_r          <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r          <= req_nxt;
    match_idx_r    <= match_idx_nxt;
    match_rank_r   <= match_rank_nxt;
    empty_idx_r    <= empty_idx_nxt;
    victim_idx_r   <= victim_idx_nxt;
    victim_bytes_r <= victim_bytes_nxt;
    prod_r         <= prod_nxt;
  end

`ifndef ASSERT_OFF
  a_free_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= FREE_W'(SLOTS))
    else $error("free slot count above slot count");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit_o |-> can_emit_i)
    else $error("result produced while output register busy");

  a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= MAX_RES_C)
    else $error("too many results for one request");

  a_trim_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEVICT) |-> victim_found_r)
    else $error("budget eviction without a free slot");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_o && res_o.last) |=> !in_stall_o)
    else $error("not ready after final result");
`endif

endmodule
`default_nettype wire

/* src/texture_pool_lru_allocator.sv */
// Top level: texture slot pool allocator with least-recent eviction.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  req_t (action, size, format, slot)
//  out_     output     out_valid/out_stall  res_t (slot, outcome, pool, last)
//  cfg_     input      cfg_valid/cfg_ready  storage budget, 32 bit
//
// An allocate accepts, scans one slot per cycle over 16 slots and decides;
// a fill step follows when it must evict a free slot. A release needs no
// scan. Each budget eviction adds a rescan of the 16 slots for the oldest
// free slot, then the eviction. The one-slot-per-cycle table scan sets the
// rate. Synchronous reset empties all slots, zeroes the pool and loads the
// default budget. A stalled output holds the sequencer at its next result.
`timescale 1ns / 1ps
`default_nettype none
module texture_pool_lru_allocator
  import tpla_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire req_t              in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output res_t                   out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [POOL_W-1:0] cfg_data
);

  logic [POOL_W-1:0] budget_r;
  logic              out_valid_r;
  res_t              out_data_r;
  logic              can_emit;
  logic              emit;
  res_t              res;
  logic [SLOT_W-1:0] scan_idx;
  slot_ent_t         scan_ent;
  tbl_cmd_t          tbl_cmd;

  // Budget register: user writes only while idle, not enforced; take them all.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RST;
    end else if (cfg_valid) begin
      budget_r <= cfg_data;
    end
  end

  // Output register: free when empty or its transfer completes this cycle.
  assign can_emit  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data_r <= res;
  end

  tpla_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_valid),
    .in_data_i  (in_data),
    .in_stall_o (in_stall),
    .budget_i   (budget_r),
    .can_emit_i (can_emit),
    .emit_o     (emit),
    .res_o      (res),
    .scan_idx_o (scan_idx),
    .scan_ent_i (scan_ent),
    .cmd_o      (tbl_cmd)
  );

  tpla_slot_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .scan_idx_i (scan_idx),
    .cmd_i      (tbl_cmd),
    .scan_ent_o (scan_ent)
  );

endmodule
`default_nettype wire
